// File: sv/sbg_pkg.sv
// Shared types, command codes and status-flag positions for the smart-battery
// register block. No dependencies; all but sbg_div refer to it by scoped names.
package sbg_pkg;

    // Operation codes of an input beat
    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_DESIGN_CAP  = 3'd0;
    localparam logic [2:0] CFG_V_FULL      = 3'd1;
    localparam logic [2:0] CFG_V_EMPTY     = 3'd2;
    localparam logic [2:0] CFG_MAX_IMB     = 3'd3;
    localparam logic [2:0] CFG_MAX_CELL    = 3'd4;
    localparam logic [2:0] CFG_RECHG_PCT   = 3'd5;
    localparam logic [2:0] CFG_CHG_CURRENT = 3'd6;
    localparam logic [2:0] CFG_CHG_VOLTAGE = 3'd7;

    // Command codes
    localparam logic [7:0] CMD_MFG_ACCESS   = 8'h00;
    localparam logic [7:0] CMD_CAP_ALARM    = 8'h01;
    localparam logic [7:0] CMD_TIME_ALARM   = 8'h02;
    localparam logic [7:0] CMD_MODE         = 8'h03;
    localparam logic [7:0] CMD_AT_RATE      = 8'h04;
    localparam logic [7:0] CMD_AR_TTF       = 8'h05;
    localparam logic [7:0] CMD_AR_TTE       = 8'h06;
    localparam logic [7:0] CMD_AR_OK        = 8'h07;
    localparam logic [7:0] CMD_TEMPERATURE  = 8'h08;
    localparam logic [7:0] CMD_VOLTAGE      = 8'h09;
    localparam logic [7:0] CMD_CURRENT      = 8'h0a;
    localparam logic [7:0] CMD_AVG_CURRENT  = 8'h0b;
    localparam logic [7:0] CMD_MAX_ERROR    = 8'h0c;
    localparam logic [7:0] CMD_REL_SOC      = 8'h0d;
    localparam logic [7:0] CMD_ABS_SOC      = 8'h0e;
    localparam logic [7:0] CMD_REM_CAP      = 8'h0f;
    localparam logic [7:0] CMD_FULL_CAP     = 8'h10;
    localparam logic [7:0] CMD_RUN_TTE      = 8'h11;
    localparam logic [7:0] CMD_AVG_TTE      = 8'h12;
    localparam logic [7:0] CMD_AVG_TTF      = 8'h13;
    localparam logic [7:0] CMD_CHG_CURRENT  = 8'h14;
    localparam logic [7:0] CMD_CHG_VOLTAGE  = 8'h15;
    localparam logic [7:0] CMD_STATUS       = 8'h16;
    localparam logic [7:0] CMD_CYCLE_COUNT  = 8'h17;
    localparam logic [7:0] CMD_DESIGN_CAP   = 8'h18;
    localparam logic [7:0] CMD_DESIGN_VOLT  = 8'h19;
    localparam logic [7:0] CMD_SPEC_INFO    = 8'h1a;
    localparam logic [7:0] CMD_MFG_DATE     = 8'h1b;
    localparam logic [7:0] CMD_SERIAL       = 8'h1c;
    localparam logic [7:0] CMD_OPT_A        = 8'h23;
    localparam logic [7:0] CMD_OPT_B        = 8'h2f;
    localparam logic [7:0] CMD_OPT_C        = 8'h3c;
    localparam logic [7:0] CMD_CELL3        = 8'h3d;
    localparam logic [7:0] CMD_CELL2        = 8'h3e;
    localparam logic [7:0] CMD_CELL1        = 8'h3f;

    // Fixed answers
    localparam logic [15:0] VAL_AR_OK      = 16'd1;
    localparam logic [15:0] VAL_TEMP       = 16'd3031;
    localparam logic [15:0] VAL_MAX_ERROR  = 16'd2;
    localparam logic [15:0] VAL_CYCLES     = 16'd9;
    localparam logic [15:0] VAL_DES_VOLT   = 16'd10800;
    localparam logic [15:0] VAL_SPEC_INFO  = 16'h0031;
    localparam logic [15:0] VAL_MFG_DATE   = 16'd20883;
    localparam logic [15:0] VAL_SERIAL     = 16'hBEAF;
    localparam logic [15:0] VAL_SAT        = 16'hFFFF;

    // Status flag bit positions
    localparam int FLAG_OCA  = 15;
    localparam int FLAG_TCA  = 14;
    localparam int FLAG_TDA  = 11;
    localparam int FLAG_RCA  = 9;
    localparam int FLAG_RTA  = 8;
    localparam int FLAG_DSG  = 6;
    localparam int FLAG_FC   = 5;
    localparam int FLAG_FD   = 4;
    localparam logic [15:0] STATUS_RESET = 16'h0080;

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  command;
        logic [15:0] write_word;
        logic [15:0] voltage_mv;
        logic signed [15:0] current_ma;
        logic signed [15:0] average_current_ma;
        logic [15:0] cell_one_mv;
        logic [15:0] cell_two_mv;
        logic [15:0] cell_three_mv;
    } sbg_in_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        one_byte;
        logic        unsupported;
    } sbg_out_t;

    typedef struct packed {
        logic [15:0] design_capacity_mah;
        logic [15:0] voltage_full_mv;
        logic [15:0] voltage_empty_mv;
        logic [15:0] max_imbalance_mv;
        logic [15:0] max_cell_mv;
        logic [6:0]  recharge_threshold_pct;
        logic [15:0] charge_current_ma;
        logic [15:0] charge_voltage_mv;
    } sbg_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAP,
        ST_CAP_W,
        ST_REL,
        ST_REL_W,
        ST_TIME,
        ST_TIME_W,
        ST_DONE
    } sbg_state_t;

endpackage

// File: sv/sbg_front.sv
// Front end: takes input beats, drops ignored operations and queues the rest.
// Depends on sbg_pkg.
module sbg_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  sbg_pkg::sbg_in_t in_data,
    output logic            head_valid,
    output sbg_pkg::sbg_in_t head,
    input  logic            pop
);

    sbg_pkg::sbg_in_t              q_mem [sbg_pkg::QDEPTH];
    logic [sbg_pkg::QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [sbg_pkg::QPTR_W:0]      count_reg, count_next;
    logic                          push;

    // full queue holds the input side
    assign in_stall   = (count_reg == (sbg_pkg::QPTR_W+1)'(sbg_pkg::QDEPTH));
    assign push       = in_valid && !in_stall && (in_data.op != sbg_pkg::OP_NONE);
    assign head_valid = (count_reg != '0);
    assign head       = q_mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_data;
        end
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid) else $error("pop from empty queue");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (sbg_pkg::QPTR_W+1)'(sbg_pkg::QDEPTH)) else $error("queue overflow");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("count did not follow push");

endmodule

// File: sv/sbg_div.sv
// Shared serial divider, one quotient bit per cycle, 32-bit dividend, 16-bit divisor.
// Depends on nothing but its ports.
module sbg_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [31:0] quotient
);

    logic [31:0] q_reg;
    logic [15:0] rem_reg, div_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [16:0] trial;
    logic        ge;

    assign trial    = {rem_reg, q_reg[31]};
    assign ge       = (trial >= {1'b0, div_reg});
    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = q_reg;

    // restoring division step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 5'd31);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? 16'(trial - {1'b0, div_reg}) : trial[15:0];
            q_reg   <= {q_reg[30:0], ge};
        end
    end

endmodule

// File: sv/sbg_exec.sv
// Back end: register state, read sequencing through the shared divider, result register.
// Depends on sbg_pkg and sbg_div.
module sbg_exec (
    input  logic             clk,
    input  logic             rst_n,
    input  sbg_pkg::sbg_cfg_t cfg,
    input  logic             head_valid,
    input  sbg_pkg::sbg_in_t head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output sbg_pkg::sbg_out_t out_data
);

    sbg_pkg::sbg_state_t state_reg, state_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [15:0] cap_reg, cap_next;
    logic [6:0]  rel_reg, rel_next;
    logic [15:0] time_reg, time_next;
    logic [15:0] status_reg, status_next;
    logic        was_full_reg, was_full_next;
    logic [15:0] volt_reg, cur_reg, avg_reg;
    logic [15:0] cell_reg [3];
    logic [15:0] mfg_reg, cap_alarm_reg, time_alarm_reg, mode_reg, at_rate_reg;
    logic        out_valid_reg, out_valid_next;
    sbg_pkg::sbg_out_t out_data_reg, out_data_next;

    logic        div_start, div_busy, div_done;
    logic [31:0] div_dividend, div_quotient;
    logic [15:0] div_divisor;

    logic        interp, need_cap, need_rel, time_go;
    logic [15:0] time_num, time_rate, dc_less_cap;
    logic        can_load, cur_neg, cur_pos, over, fc_new;
    logic [15:0] flags;
    logic [1:0]  ce_status, ce_plain;
    logic        upd_write, upd_meas;

    sbg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    function automatic logic [15:0] mag16(input logic [15:0] v);
        mag16 = v[15] ? 16'(-v) : v;
    endfunction

    function automatic logic [15:0] adiff(input logic [15:0] a, input logic [15:0] b);
        adiff = (a > b) ? 16'(a - b) : 16'(b - a);
    endfunction

    // charge permission with full-charge hysteresis: returns {ok, was_full}
    function automatic logic [1:0] charge_eval(
        input logic        wf_in,
        input logic        fc,
        input logic [6:0]  rel,
        input logic [6:0]  thr,
        input logic [15:0] c1,
        input logic [15:0] c2,
        input logic [15:0] c3,
        input logic [15:0] imb,
        input logic [15:0] cmax
    );
        logic above;
        above = (rel > thr);
        if ((wf_in || fc) && above)
        begin
            charge_eval = 2'b01;
        end
        else if (adiff(c1, c2) > imb || adiff(c2, c3) > imb || adiff(c3, c1) > imb)
        begin
            charge_eval = {1'b0, above};
        end
        else if (c1 > cmax || c2 > cmax || c3 > cmax)
        begin
            charge_eval = {1'b0, above};
        end
        else
        begin
            charge_eval = 2'b10;
        end
    endfunction

    assign interp      = (volt_reg > cfg.voltage_empty_mv) && (volt_reg < cfg.voltage_full_mv);
    assign need_cap    = cmd_reg inside {sbg_pkg::CMD_AR_TTF, sbg_pkg::CMD_AR_TTE,
                         sbg_pkg::CMD_REL_SOC, sbg_pkg::CMD_ABS_SOC, sbg_pkg::CMD_REM_CAP,
                         sbg_pkg::CMD_RUN_TTE, sbg_pkg::CMD_AVG_TTE, sbg_pkg::CMD_AVG_TTF,
                         sbg_pkg::CMD_CHG_CURRENT, sbg_pkg::CMD_CHG_VOLTAGE,
                         sbg_pkg::CMD_STATUS};
    assign need_rel    = cmd_reg inside {sbg_pkg::CMD_REL_SOC, sbg_pkg::CMD_ABS_SOC,
                         sbg_pkg::CMD_CHG_CURRENT, sbg_pkg::CMD_CHG_VOLTAGE,
                         sbg_pkg::CMD_STATUS};
    assign dc_less_cap = 16'(cfg.design_capacity_mah - cap_reg);
    assign can_load    = !out_valid_reg || !out_stall;
    assign upd_meas    = (state_reg == sbg_pkg::ST_IDLE) && head_valid
                         && (head.op == sbg_pkg::OP_UPDATE);
    assign upd_write   = (state_reg == sbg_pkg::ST_IDLE) && head_valid
                         && (head.op == sbg_pkg::OP_WRITE);

    // time-field operand selection
    always_comb
    begin
        time_go   = 1'b0;
        time_num  = cap_reg;
        time_rate = mag16(avg_reg);
        case (cmd_reg)
            sbg_pkg::CMD_AR_TTF:
            begin
                time_go   = !at_rate_reg[15] && (at_rate_reg != '0);
                time_num  = dc_less_cap;
                time_rate = mag16(at_rate_reg);
            end
            sbg_pkg::CMD_AR_TTE:
            begin
                time_go   = at_rate_reg[15];
                time_rate = mag16(at_rate_reg);
            end
            sbg_pkg::CMD_RUN_TTE:
            begin
                time_go   = cur_reg[15];
                time_rate = mag16(cur_reg);
            end
            sbg_pkg::CMD_AVG_TTE:
            begin
                time_go   = avg_reg[15];
            end
            sbg_pkg::CMD_AVG_TTF:
            begin
                time_go   = !avg_reg[15] && (avg_reg != '0);
                time_num  = dc_less_cap;
            end
            default:
            begin
                time_go   = 1'b0;
            end
        endcase
    end

    // status word as a status read leaves it
    assign cur_neg = cur_reg[15];
    assign cur_pos = !cur_reg[15] && (cur_reg != '0);
    assign over    = cur_pos && (volt_reg > cfg.voltage_full_mv);
    assign fc_new  = !cur_neg && (rel_reg >= 7'd100);
    always_comb
    begin
        flags = status_reg;
        flags[sbg_pkg::FLAG_DSG] = !cur_pos;
        flags[sbg_pkg::FLAG_RCA] = (cap_alarm_reg != '0) && (cap_reg < cap_alarm_reg);
        flags[sbg_pkg::FLAG_RTA] = (time_alarm_reg != '0) && (cap_reg < cap_alarm_reg);
        flags[sbg_pkg::FLAG_FD]  = (19'(cap_reg) * 19'd5) < 19'(cfg.design_capacity_mah);
        flags[sbg_pkg::FLAG_TDA] = cur_neg && (cap_reg == '0);
        flags[sbg_pkg::FLAG_FC]  = fc_new;
        flags[sbg_pkg::FLAG_OCA] = over;
        flags[sbg_pkg::FLAG_TCA] = over || !ce_status[1];
    end

    assign ce_status = charge_eval(was_full_reg, fc_new, rel_reg,
                                   cfg.recharge_threshold_pct, cell_reg[0], cell_reg[1],
                                   cell_reg[2], cfg.max_imbalance_mv, cfg.max_cell_mv);
    assign ce_plain  = charge_eval(was_full_reg, status_reg[sbg_pkg::FLAG_FC], rel_reg,
                                   cfg.recharge_threshold_pct, cell_reg[0], cell_reg[1],
                                   cell_reg[2], cfg.max_imbalance_mv, cfg.max_cell_mv);

    // read sequencer
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        cap_next       = cap_reg;
        rel_next       = rel_reg;
        time_next      = time_reg;
        status_next    = status_reg;
        was_full_next  = was_full_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        div_start      = 1'b0;
        div_dividend   = 32'(16'(volt_reg - cfg.voltage_empty_mv)) * 32'(cfg.design_capacity_mah);
        div_divisor    = 16'(cfg.voltage_full_mv - cfg.voltage_empty_mv);
        case (state_reg)
            sbg_pkg::ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop = 1'b1;
                    if (head.op == sbg_pkg::OP_READ)
                    begin
                        cmd_next   = head.command;
                        state_next = sbg_pkg::ST_CAP;
                    end
                end
            end
            sbg_pkg::ST_CAP:
            begin
                if (need_cap && interp)
                begin
                    div_start  = 1'b1;
                    state_next = sbg_pkg::ST_CAP_W;
                end
                else
                begin
                    cap_next   = (volt_reg >= cfg.voltage_full_mv) ? cfg.design_capacity_mah
                                                                    : '0;
                    state_next = sbg_pkg::ST_REL;
                end
            end
            sbg_pkg::ST_CAP_W:
            begin
                if (div_done)
                begin
                    cap_next   = div_quotient[15:0];
                    state_next = sbg_pkg::ST_REL;
                end
            end
            sbg_pkg::ST_REL:
            begin
                div_dividend = 32'(cap_reg) * 32'd100;
                div_divisor  = cfg.design_capacity_mah;
                if (need_rel && (cfg.design_capacity_mah != '0))
                begin
                    div_start  = 1'b1;
                    state_next = sbg_pkg::ST_REL_W;
                end
                else
                begin
                    rel_next   = '0;
                    state_next = sbg_pkg::ST_TIME;
                end
            end
            sbg_pkg::ST_REL_W:
            begin
                if (div_done)
                begin
                    rel_next   = (div_quotient > 32'd100) ? 7'd100 : div_quotient[6:0];
                    state_next = sbg_pkg::ST_TIME;
                end
            end
            sbg_pkg::ST_TIME:
            begin
                div_dividend = 32'(time_num) * 32'd60;
                div_divisor  = time_rate;
                if (time_go && (time_rate != '0))
                begin
                    div_start  = 1'b1;
                    state_next = sbg_pkg::ST_TIME_W;
                end
                else
                begin
                    time_next  = sbg_pkg::VAL_SAT;
                    state_next = sbg_pkg::ST_DONE;
                end
            end
            sbg_pkg::ST_TIME_W:
            begin
                if (div_done)
                begin
                    time_next  = (div_quotient[31:16] != '0) ? sbg_pkg::VAL_SAT
                                                              : div_quotient[15:0];
                    state_next = sbg_pkg::ST_DONE;
                end
            end
            sbg_pkg::ST_DONE:
            begin
                if (can_load)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.read_data   = '0;
                    out_data_next.one_byte    = 1'b0;
                    out_data_next.unsupported = 1'b0;
                    state_next                = sbg_pkg::ST_IDLE;
                    case (cmd_reg)
                        sbg_pkg::CMD_MFG_ACCESS:  out_data_next.read_data = mfg_reg;
                        sbg_pkg::CMD_CAP_ALARM:   out_data_next.read_data = cap_alarm_reg;
                        sbg_pkg::CMD_TIME_ALARM:  out_data_next.read_data = time_alarm_reg;
                        sbg_pkg::CMD_MODE:        out_data_next.read_data = mode_reg;
                        sbg_pkg::CMD_AT_RATE:     out_data_next.read_data = at_rate_reg;
                        sbg_pkg::CMD_AR_TTF, sbg_pkg::CMD_AR_TTE, sbg_pkg::CMD_RUN_TTE,
                        sbg_pkg::CMD_AVG_TTE, sbg_pkg::CMD_AVG_TTF:
                            out_data_next.read_data = time_reg;
                        sbg_pkg::CMD_AR_OK:       out_data_next.read_data = sbg_pkg::VAL_AR_OK;
                        sbg_pkg::CMD_TEMPERATURE: out_data_next.read_data = sbg_pkg::VAL_TEMP;
                        sbg_pkg::CMD_VOLTAGE:     out_data_next.read_data = volt_reg;
                        sbg_pkg::CMD_CURRENT:     out_data_next.read_data = cur_reg;
                        sbg_pkg::CMD_AVG_CURRENT: out_data_next.read_data = avg_reg;
                        sbg_pkg::CMD_MAX_ERROR:
                        begin
                            out_data_next.read_data = sbg_pkg::VAL_MAX_ERROR;
                            out_data_next.one_byte  = 1'b1;
                        end
                        sbg_pkg::CMD_REL_SOC:
                        begin
                            out_data_next.read_data = 16'(rel_reg);
                            out_data_next.one_byte  = 1'b1;
                        end
                        sbg_pkg::CMD_ABS_SOC:
                        begin
                            out_data_next.read_data = 16'(rel_reg) + 16'd3;
                            out_data_next.one_byte  = 1'b1;
                        end
                        sbg_pkg::CMD_REM_CAP:     out_data_next.read_data = cap_reg;
                        sbg_pkg::CMD_FULL_CAP, sbg_pkg::CMD_DESIGN_CAP:
                            out_data_next.read_data = cfg.design_capacity_mah;
                        sbg_pkg::CMD_CHG_CURRENT:
                        begin
                            out_data_next.read_data = ce_plain[1] ? cfg.charge_current_ma : '0;
                            was_full_next           = ce_plain[0];
                        end
                        sbg_pkg::CMD_CHG_VOLTAGE:
                        begin
                            out_data_next.read_data = ce_plain[1] ? cfg.charge_voltage_mv : '0;
                            was_full_next           = ce_plain[0];
                        end
                        sbg_pkg::CMD_STATUS:
                        begin
                            out_data_next.read_data = flags;
                            status_next             = flags;
                            if (!over)
                            begin
                                was_full_next = ce_status[0];
                            end
                        end
                        sbg_pkg::CMD_CYCLE_COUNT: out_data_next.read_data = sbg_pkg::VAL_CYCLES;
                        sbg_pkg::CMD_DESIGN_VOLT: out_data_next.read_data = sbg_pkg::VAL_DES_VOLT;
                        sbg_pkg::CMD_SPEC_INFO:   out_data_next.read_data = sbg_pkg::VAL_SPEC_INFO;
                        sbg_pkg::CMD_MFG_DATE:    out_data_next.read_data = sbg_pkg::VAL_MFG_DATE;
                        sbg_pkg::CMD_SERIAL:      out_data_next.read_data = sbg_pkg::VAL_SERIAL;
                        sbg_pkg::CMD_OPT_A, sbg_pkg::CMD_OPT_B, sbg_pkg::CMD_OPT_C:
                            out_data_next.read_data = '0;
                        sbg_pkg::CMD_CELL3:       out_data_next.read_data = cell_reg[2];
                        sbg_pkg::CMD_CELL2:       out_data_next.read_data = cell_reg[1];
                        sbg_pkg::CMD_CELL1:       out_data_next.read_data = cell_reg[0];
                        default:                  out_data_next.unsupported = 1'b1;
                    endcase
                end
            end
            default:
            begin
                state_next = sbg_pkg::ST_IDLE;
            end
        endcase
    end

    // control and read state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sbg_pkg::ST_IDLE;
            status_reg    <= sbg_pkg::STATUS_RESET;
            was_full_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            status_reg    <= status_next;
            was_full_reg  <= was_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // measurement and host-writable registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volt_reg       <= '0;
            cur_reg        <= '0;
            avg_reg        <= '0;
            cell_reg[0]    <= '0;
            cell_reg[1]    <= '0;
            cell_reg[2]    <= '0;
            mfg_reg        <= '0;
            cap_alarm_reg  <= 16'd250;
            time_alarm_reg <= 16'd10;
            mode_reg       <= 16'd1;
            at_rate_reg    <= '0;
        end
        else
        begin
            if (upd_meas)
            begin
                volt_reg    <= head.voltage_mv;
                cur_reg     <= head.current_ma;
                avg_reg     <= head.average_current_ma;
                cell_reg[0] <= head.cell_one_mv;
                cell_reg[1] <= head.cell_two_mv;
                cell_reg[2] <= head.cell_three_mv;
            end
            if (upd_write)
            begin
                case (head.command)
                    sbg_pkg::CMD_MFG_ACCESS: mfg_reg        <= head.write_word;
                    sbg_pkg::CMD_CAP_ALARM:  cap_alarm_reg  <= head.write_word;
                    sbg_pkg::CMD_TIME_ALARM: time_alarm_reg <= head.write_word;
                    sbg_pkg::CMD_MODE:       mode_reg       <= head.write_word;
                    sbg_pkg::CMD_AT_RATE:    at_rate_reg    <= head.write_word;
                    default:                 ;
                endcase
            end
        end
    end

    // working values of a read
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        cap_reg      <= cap_next;
        rel_reg      <= rel_next;
        time_reg     <= time_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_start_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy) else $error("divider restarted while busy");
    a_wait_has_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sbg_pkg::ST_REL_W || state_reg == sbg_pkg::ST_CAP_W
         || state_reg == sbg_pkg::ST_TIME_W) |-> (div_busy || div_done))
        else $error("waiting on an idle divider");
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == sbg_pkg::ST_IDLE)) else $error("pop mid read");
    a_rel_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sbg_pkg::ST_DONE) |-> (rel_reg <= 7'd100))
        else $error("percentage out of range");

endmodule

// File: sv/smart_battery_gauge_registers.sv
// Smart-battery register slave for a three-cell pack. The back end applies measurement
// updates and host word writes from idle; a host read runs each division it needs
// (capacity interpolation, then either the percentage or a time field, never both) on
// the single shared bit-serial divider. A two-beat queue sits between input and back
// end, and a result register lets the next item be taken while an answer waits. Op
// code 3 is dropped on entry.
module smart_battery_gauge_registers (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  sbg_pkg::sbg_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output sbg_pkg::sbg_out_t out_data,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

    sbg_pkg::sbg_cfg_t cfg_reg;
    sbg_pkg::sbg_in_t  head;
    logic              head_valid, pop;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.design_capacity_mah    <= 16'd2500;
            cfg_reg.voltage_full_mv        <= 16'd12600;
            cfg_reg.voltage_empty_mv       <= 16'd9300;
            cfg_reg.max_imbalance_mv       <= 16'd200;
            cfg_reg.max_cell_mv            <= 16'd4200;
            cfg_reg.recharge_threshold_pct <= 7'd80;
            cfg_reg.charge_current_ma      <= 16'd357;
            cfg_reg.charge_voltage_mv      <= 16'd12600;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sbg_pkg::CFG_DESIGN_CAP:  cfg_reg.design_capacity_mah    <= cfg_data;
                sbg_pkg::CFG_V_FULL:      cfg_reg.voltage_full_mv        <= cfg_data;
                sbg_pkg::CFG_V_EMPTY:     cfg_reg.voltage_empty_mv       <= cfg_data;
                sbg_pkg::CFG_MAX_IMB:     cfg_reg.max_imbalance_mv       <= cfg_data;
                sbg_pkg::CFG_MAX_CELL:    cfg_reg.max_cell_mv            <= cfg_data;
                sbg_pkg::CFG_RECHG_PCT:   cfg_reg.recharge_threshold_pct <= cfg_data[6:0];
                sbg_pkg::CFG_CHG_CURRENT: cfg_reg.charge_current_ma      <= cfg_data;
                sbg_pkg::CFG_CHG_VOLTAGE: cfg_reg.charge_voltage_mv      <= cfg_data;
                default:                  ;
            endcase
        end
    end

    sbg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    sbg_exec u_exec (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule
